### sv/lwm_pkg.sv
// lwm_pkg: shared types and constants of the like wildcard matcher
// used by lwm_cell and like_wildcard_matcher; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lwm_pkg;

    localparam int MAX_ELEMENTS_DEF = 32;
    localparam int CHAR_W           = 8;
    localparam int MAP_W            = 256;

    localparam logic [7:0] CH_RUN    = 8'h25; // %
    localparam logic [7:0] CH_ONE    = 8'h5f; // _
    localparam logic [7:0] CH_ESC    = 8'h5c; // backslash
    localparam logic [7:0] CH_LBRK   = 8'h5b; // [
    localparam logic [7:0] CH_NEG    = 8'h5e; // ^
    localparam logic [7:0] CH_RBRK   = 8'h5d; // ]
    localparam logic [7:0] CH_DASH   = 8'h2d; // -

    typedef enum logic [1:0] {
        CMD_PAT_BYTE = 2'd0,
        CMD_PAT_END  = 2'd1,
        CMD_SUB_BYTE = 2'd2,
        CMD_SUB_END  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_LIT   = 2'd0,
        KIND_ONE   = 2'd1,
        KIND_RUN   = 2'd2,
        KIND_CLASS = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STEP_HOLD = 2'd0,
        STEP_CHAR = 2'd1,
        STEP_INIT = 2'd2
    } t_step;

    // broadcast control for the row of cells
    typedef struct packed {
        t_step       step;
        logic        add;
        t_kind       kind;
        logic [7:0]  lit;
        logic        clr;
        logic        set_en;
        logic [7:0]  lo;
        logic [7:0]  hi;
        logic        inv;
    } t_cell_ctl;

endpackage

`default_nettype wire

### sv/lwm_cell.sv
// lwm_cell: one pattern element of the nfa row (kind, literal, class map, active bit)
// depends on lwm_pkg
`timescale 1ns / 1ps
`default_nettype none

module lwm_cell (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire lwm_pkg::t_cell_ctl i_ctl,
    input  wire                  i_sel_add,
    input  wire                  i_sel_cls,
    input  wire                  i_en,
    input  wire  [7:0]           i_char,
    input  wire                  i_prev_fwd,
    input  wire                  i_clos_in,
    input  wire                  i_init_in,
    output logic                 o_fwd,
    output logic                 o_clos,
    output logic                 o_init,
    output logic                 o_act
);
    import lwm_pkg::*;

    t_kind              r_kind;
    logic [7:0]         r_lit;
    logic [MAP_W-1:0]   r_map;
    logic               r_act;
    logic [MAP_W-1:0]   n_map;
    logic [MAP_W-1:0]   w_mask;
    logic               w_acc;
    logic               w_run;
    logic               w_hit;
    logic               w_s;

    always_comb begin
        case (r_kind)
            KIND_LIT:   w_acc = (r_lit == i_char);
            KIND_CLASS: w_acc = r_map[i_char];
            default:    w_acc = 1'b1;
        endcase
    end

    assign w_run  = i_en && (r_kind == KIND_RUN);
    assign w_hit  = r_act && i_en && w_acc;
    assign o_fwd  = w_hit && !w_run;
    // next active bit before and after the run closure
    assign w_s    = i_prev_fwd || (w_hit && w_run) || i_clos_in;
    assign o_clos = w_s && w_run;
    assign o_init = i_init_in && w_run;
    assign o_act  = r_act;

    always_comb begin
        for (int v = 0; v < MAP_W; v++) begin
            w_mask[v] = i_ctl.set_en && (8'(v) >= i_ctl.lo) && (8'(v) <= i_ctl.hi);
        end
        n_map = r_map;
        if (i_sel_add && i_ctl.clr) begin
            n_map = '0;
        end
        if (i_sel_cls) begin
            n_map = n_map | w_mask;
            if (i_ctl.inv) begin
                n_map = ~n_map;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_map <= n_map;
        if (i_sel_add && i_ctl.add) begin
            r_kind <= i_ctl.kind;
            r_lit  <= i_ctl.lit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            case (i_ctl.step)
                STEP_CHAR: r_act <= w_s;
                STEP_INIT: r_act <= i_init_in;
                default:   r_act <= r_act;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/like_wildcard_matcher.sv
// like_wildcard_matcher: top level, pattern compiler and row of nfa cells
// depends on lwm_pkg and lwm_cell
//
// Takes one transaction per cycle: pattern bytes, end of pattern, subject bytes,
// end of subject. Every item is handled in the cycle it is accepted; the nfa row
// updates all positions at once with a ripple of the % closure through the cells.
// A result (matched, pattern_error) is captured at the accepted end of subject and
// sits in an output register; input keeps flowing while that register is free or
// being drained. Subject items before end of pattern are dropped.
`timescale 1ns / 1ps
`default_nettype none

module like_wildcard_matcher #(
    parameter int MaxElements = lwm_pkg::MAX_ELEMENTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire  [15:0] i_s_tdata,   // [1:0] command, [9:2] char_value, rest zero
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [7:0]  o_m_tdata    // [0] matched, [1] pattern_error, rest zero
);
    import lwm_pkg::*;

    localparam int CW = $clog2(MaxElements + 1);

    typedef enum logic [2:0] {
        PH_NORMAL, PH_ESC, PH_CSTART, PH_CLASS, PH_CMEMBER, PH_CESC, PH_DONE
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [CW-1:0] r_cnt, n_cnt;
    logic         r_err, n_err;
    logic         r_neg, n_neg;
    logic         r_rp, n_rp;
    logic [7:0]   r_rsc, n_rsc;
    logic         r_act_end;
    logic         r_out_valid, r_matched, r_perr;

    t_cell_ctl    w_ctl;
    logic         w_acc;
    t_cmd         w_cmd;
    logic [7:0]   w_ch;
    logic         w_cls_op;
    logic         w_add_ok;
    logic         w_result;
    logic         w_matched;
    logic [CW-1:0] w_cls_idx;

    logic [MaxElements-1:0] w_fwd, w_clos, w_init, w_act;
    logic [MaxElements:0]   w_act_all;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign w_acc      = i_s_tvalid && o_s_tready;
    assign w_cmd      = t_cmd'(i_s_tdata[1:0]);
    assign w_ch       = i_s_tdata[9:2];
    assign w_cls_idx  = r_cnt - CW'(1);

    // pattern compiler and command decode (subject steps, result)
    always_comb begin
        t_phase     ph;
        logic       err;
        logic [CW-1:0] cnt;
        logic       add_req;
        logic       member;
        ph       = r_phase;
        err      = r_err;
        cnt      = r_cnt;
        add_req  = 1'b0;
        member   = 1'b0;
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_err    = r_err;
        n_neg    = r_neg;
        n_rp     = r_rp;
        n_rsc    = r_rsc;
        w_ctl    = '0;
        w_ctl.step = STEP_HOLD;
        w_ctl.kind = KIND_LIT;
        w_cls_op = 1'b0;
        w_result = 1'b0;
        if (w_acc) begin
            case (w_cmd)
                CMD_PAT_BYTE: begin
                    if (r_phase == PH_DONE) begin
                        ph = PH_NORMAL;
                        err = 1'b0;
                        cnt = '0;
                        n_neg = 1'b0;
                        n_rp = 1'b0;
                        n_phase = PH_NORMAL;
                        n_cnt = '0;
                        n_err = 1'b0;
                    end
                    if (!err) begin
                        case (ph)
                            PH_NORMAL: begin
                                add_req = 1'b1;
                                if (w_ch == CH_RUN) begin
                                    w_ctl.kind = KIND_RUN;
                                end else if (w_ch == CH_ONE) begin
                                    w_ctl.kind = KIND_ONE;
                                end else if (w_ch == CH_ESC) begin
                                    add_req = 1'b0;
                                    n_phase = PH_ESC;
                                end else if (w_ch == CH_LBRK) begin
                                    w_ctl.kind = KIND_CLASS;
                                    w_ctl.clr = 1'b1;
                                    if (cnt < CW'(MaxElements)) begin
                                        n_neg = 1'b0;
                                        n_rp = 1'b0;
                                        n_phase = PH_CSTART;
                                    end
                                end else begin
                                    w_ctl.kind = KIND_LIT;
                                    w_ctl.lit = w_ch;
                                end
                            end
                            PH_ESC: begin
                                add_req = 1'b1;
                                w_ctl.lit = w_ch;
                                n_phase = PH_NORMAL;
                            end
                            PH_CESC: member = 1'b1;
                            PH_CSTART, PH_CLASS, PH_CMEMBER: begin
                                if (ph == PH_CSTART && w_ch == CH_NEG) begin
                                    n_neg = 1'b1;
                                    n_phase = PH_CLASS;
                                end else if (w_ch == CH_RBRK) begin
                                    w_cls_op = 1'b1;
                                    w_ctl.set_en = r_rp;
                                    w_ctl.lo = CH_DASH;
                                    w_ctl.hi = CH_DASH;
                                    w_ctl.inv = r_neg;
                                    n_neg = 1'b0;
                                    n_rp = 1'b0;
                                    n_phase = PH_NORMAL;
                                end else if (w_ch == CH_ESC) begin
                                    n_phase = PH_CESC;
                                end else if (w_ch == CH_DASH && ph == PH_CMEMBER && !r_rp) begin
                                    n_rp = 1'b1;
                                end else begin
                                    member = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                CMD_PAT_END: begin
                    if (r_phase != PH_DONE) begin
                        if (!r_err) begin
                            if (r_phase == PH_ESC) begin
                                add_req = 1'b1;
                                w_ctl.lit = CH_ESC;
                            end else if (r_phase != PH_NORMAL) begin
                                n_err = 1'b1;
                            end
                        end
                        n_phase = PH_DONE;
                        w_ctl.step = STEP_INIT;
                    end
                end
                CMD_SUB_BYTE: begin
                    if (r_phase == PH_DONE) begin
                        w_ctl.step = STEP_CHAR;
                    end
                end
                default: begin
                    if (r_phase == PH_DONE) begin
                        w_result = 1'b1;
                        w_ctl.step = STEP_INIT;
                    end
                end
            endcase
        end
        if (member) begin
            w_cls_op = 1'b1;
            w_ctl.set_en = 1'b1;
            if (r_rp) begin
                w_ctl.lo = r_rsc;
                w_ctl.hi = w_ch;
                n_rp = 1'b0;
                n_phase = PH_CLASS;
            end else begin
                w_ctl.lo = w_ch;
                w_ctl.hi = w_ch;
                n_rsc = w_ch;
                n_phase = PH_CMEMBER;
            end
        end
        w_add_ok = add_req && (cnt < CW'(MaxElements));
        w_ctl.add = w_add_ok;
        if (add_req) begin
            if (w_add_ok) begin
                n_cnt = cnt + CW'(1);
            end else begin
                n_err = 1'b1;
            end
        end
    end

    genvar p;
    generate
        for (p = 0; p < MaxElements; p++) begin : g_cell
            logic w_prev_fwd, w_clos_in, w_init_in;
            if (p == 0) begin : g_head
                assign w_prev_fwd = 1'b0;
                assign w_clos_in  = 1'b0;
                assign w_init_in  = 1'b1;
            end else begin : g_link
                assign w_prev_fwd = w_fwd[p-1];
                assign w_clos_in  = w_clos[p-1];
                assign w_init_in  = w_init[p-1];
            end
            lwm_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_sel_add  (w_add_ok && (((r_phase == PH_DONE) ? '0 : r_cnt) == CW'(p))),
                .i_sel_cls  (w_cls_op && (w_cls_idx == CW'(p))),
                .i_en       (r_cnt > CW'(p)),
                .i_char     (w_ch),
                .i_prev_fwd (w_prev_fwd),
                .i_clos_in  (w_clos_in),
                .i_init_in  (w_init_in),
                .o_fwd      (w_fwd[p]),
                .o_clos     (w_clos[p]),
                .o_init     (w_init[p]),
                .o_act      (w_act[p])
            );
        end
    endgenerate

    assign w_act_all = {r_act_end, w_act};
    assign w_matched = !r_err && w_act_all[r_cnt];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_NORMAL;
            r_cnt       <= '0;
            r_err       <= 1'b0;
            r_neg       <= 1'b0;
            r_rp        <= 1'b0;
            r_rsc       <= '0;
            r_act_end   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_err   <= n_err;
            r_neg   <= n_neg;
            r_rp    <= n_rp;
            r_rsc   <= n_rsc;
            case (w_ctl.step)
                STEP_CHAR: r_act_end <= w_fwd[MaxElements-1] || w_clos[MaxElements-1];
                STEP_INIT: r_act_end <= w_init[MaxElements-1];
                default:   r_act_end <= r_act_end;
            endcase
            if (w_result) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result) begin
            r_matched <= w_matched;
            r_perr    <= r_err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_perr, r_matched};

    // a new result only follows an accepted end of subject
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_acc && w_cmd == CMD_SUB_END))
        else $error("result without end of subject");

    a_err_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[1]))
        else $error("match reported with pattern error");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MaxElements))
        else $error("element count beyond store");

    a_class_has_elem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CSTART || r_phase == PH_CLASS || r_phase == PH_CMEMBER)
        |-> r_cnt != '0)
        else $error("class phase with no element");

endmodule

`default_nettype wire
